FILE: sv/tgb_pkg.sv
`timescale 1ns / 1ps
// Package for the text grid blit engine: grid sizes, item types, palettes.
// No dependencies.
package tgb_pkg;
	localparam int MaxRows = 64;
	localparam int MaxCols = 128;
	localparam int RowW = 6;
	localparam int ColW = 7;
	localparam int Cells = MaxRows * MaxCols;
	localparam int AddrW = RowW + ColW;
	localparam int CharW = 21;
	localparam int AttrW = 10;

	typedef enum logic [2:0] {
		FN_PUT = 3'd0, FN_FILL = 3'd1, FN_COPY = 3'd2, FN_READ = 3'd3,
		FN_BELL = 3'd4, FN_CURSOR = 3'd5, FN_VIS = 3'd6, FN_TAKE = 3'd7
	} func_t;

	typedef struct packed {
		logic [2:0]  func;
		logic [5:0]  row;
		logic [6:0]  col;
		logic [6:0]  end_row;
		logic [7:0]  end_col;
		logic [5:0]  dst_row;
		logic [6:0]  dst_col;
		logic [20:0] char_code;
		logic [2:0]  fg_index;
		logic [2:0]  bg_index;
		logic [3:0]  format_flags;
		logic        flag_value;
	} in_item_t;

	typedef struct packed {
		logic [20:0] read_char;
		logic [2:0]  attr_flags;
		logic [23:0] fg_rgb;
		logic [23:0] bg_rgb;
		logic [5:0]  dirty_top;
		logic [6:0]  dirty_left;
		logic [6:0]  dirty_rows;
		logic [7:0]  dirty_cols;
		logic [7:0]  bells;
		logic        cursor_touched;
		logic        cursor_shown;
	} out_item_t;

	function automatic logic [23:0] pal_normal(input logic [2:0] i);
		case (i)
			3'd0: return 24'h000000;
			3'd1: return 24'h800000;
			3'd2: return 24'h008000;
			3'd3: return 24'h808000;
			3'd4: return 24'h000080;
			3'd5: return 24'h800080;
			3'd6: return 24'h008080;
			default: return 24'hc0c0c0;
		endcase
	endfunction

	function automatic logic [23:0] pal_bright(input logic [2:0] i);
		case (i)
			3'd0: return 24'h808080;
			3'd1: return 24'hff0000;
			3'd2: return 24'h00ff00;
			3'd3: return 24'hffff00;
			3'd4: return 24'h0000ff;
			3'd5: return 24'hff00ff;
			3'd6: return 24'h00ffff;
			default: return 24'hffffff;
		endcase
	endfunction
endpackage

FILE: sv/tgb_ram.sv
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module tgb_ram #(
	parameter int Width = 8,
	parameter int Depth = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] waddr,
	input  logic [Width-1:0]         wdata,
	input  logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

FILE: sv/text_grid_blit_engine_top.sv
`timescale 1ns / 1ps
// Top level of the text grid blit engine: sequencer, cell store, dirty rectangle.
// Depends on tgb_pkg and tgb_ram.
//
// Usage: items enter on in_valid/in_ready as in_item_t; one result per item
// leaves on out_valid/out_ready as out_item_t, in order.
// After reset the store is swept to zero, one cell per cycle;
// in_ready stays low during the sweep.
// Sequence from acceptance to out_valid: put, bell, cursor, visibility and take
// go straight to the done state; read first passes a read state that registers
// the RAM output. Fill writes one cell per cycle. Copy reads then writes each
// cell through the single RAM port pair, alternating a read and a write state.
// An empty fill or copy goes from its first state straight to done. The input
// is taken again in the cycle after the result is loaded.
// The result sits in an output register; the next item is taken while it
// waits, but a finished item waits for the register to be free, so a
// stalled receiver backs up the input channel after one item.
module text_grid_blit_engine_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tgb_pkg::in_item_t in_item,
	output logic              out_valid,
	input  logic              out_ready,
	output tgb_pkg::out_item_t out_item
);
	import tgb_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR, ST_IDLE, ST_FILL, ST_CRD, ST_CWR, ST_RD, ST_DONE
	} state_t;

	state_t state_q;
	in_item_t it_q;
	logic [AddrW-1:0] clr_q;
	logic [RowW-1:0] i_q;
	logic [ColW-1:0] j_q;
	logic [5:0] d_top_q;
	logic [6:0] d_left_q, d_rows_q;
	logic [7:0] d_cols_q, bells_q;
	logic touched_q, shown_q;
	logic [20:0] rc_q;
	logic [2:0] rf_q;
	logic [23:0] rfg_q, rbg_q;

	// memory ports
	logic we;
	logic [AddrW-1:0] waddr, raddr;
	logic [CharW-1:0] wchar, rchar;
	logic [AttrW-1:0] wattr, rattr;

	tgb_ram #(.Width(CharW), .Depth(Cells)) u_char (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wchar), .raddr(raddr), .rdata(rchar));
	tgb_ram #(.Width(AttrW), .Depth(Cells)) u_attr (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wattr), .raddr(raddr), .rdata(rattr));

	// copy and fill geometry from the held item
	logic [7:0] ch_a, ch_b, cw_a, cw_b, ch_n, cw_n;
	logic [7:0] fh_n, fw_n, fer, fec;
	logic copy_ok, fill_ok;
	logic [RowW-1:0] r_off;
	logic [ColW-1:0] c_off;
	logic [RowW-1:0] src_r, dst_r;
	logic [ColW-1:0] src_c, dst_c;

	always_comb begin
		ch_a = {1'b0, it_q.end_row} - {2'b0, it_q.row};
		ch_b = 8'(MaxRows) - {2'b0, it_q.row};
		if (ch_b < ch_a) ch_a = ch_b;
		ch_b = 8'(MaxRows) - {2'b0, it_q.dst_row};
		ch_n = (ch_b < ch_a) ? ch_b : ch_a;
		cw_a = it_q.end_col - {1'b0, it_q.col};
		cw_b = 8'(MaxCols) - {1'b0, it_q.col};
		if (cw_b < cw_a) cw_a = cw_b;
		cw_b = 8'(MaxCols) - {1'b0, it_q.dst_col};
		cw_n = (cw_b < cw_a) ? cw_b : cw_a;
		copy_ok = ({1'b0, it_q.end_row} > {2'b0, it_q.row}) &&
			(it_q.end_col > {1'b0, it_q.col});
		fer = ({1'b0, it_q.end_row} > 8'(MaxRows)) ? 8'(MaxRows) : {1'b0, it_q.end_row};
		fec = (it_q.end_col > 8'(MaxCols)) ? 8'(MaxCols) : it_q.end_col;
		fill_ok = (fer > {2'b0, it_q.row}) && (fec > {1'b0, it_q.col});
		fh_n = fer - {2'b0, it_q.row};
		fw_n = fec - {1'b0, it_q.col};
		// walk backward along an axis when the destination lies past the source
		r_off = (it_q.dst_row <= it_q.row) ? i_q :
			RowW'(ch_n - 8'd1 - {2'b0, i_q});
		c_off = (it_q.dst_col <= it_q.col) ? j_q :
			ColW'(cw_n - 8'd1 - {1'b0, j_q});
		src_r = it_q.row + r_off;
		src_c = it_q.col + c_off;
		dst_r = it_q.dst_row + r_off;
		dst_c = it_q.dst_col + c_off;
	end

	// drive memory from the sequencer
	always_comb begin
		we = 1'b0;
		waddr = clr_q;
		wchar = it_q.char_code;
		wattr = {it_q.format_flags, it_q.bg_index, it_q.fg_index};
		raddr = {src_r, src_c};
		case (state_q)
			ST_CLEAR: begin
				we = 1'b1; wchar = '0; wattr = '0;
			end
			ST_FILL: begin
				we = fill_ok; waddr = {RowW'(it_q.row + i_q), ColW'(it_q.col + j_q)};
			end
			ST_CWR: begin
				we = 1'b1; waddr = {dst_r, dst_c}; wchar = rchar; wattr = rattr;
			end
			ST_IDLE: begin
				raddr = {in_item.row, in_item.col};
				we = in_valid && (in_item.func == FN_PUT);
				waddr = {in_item.row, in_item.col};
				wchar = in_item.char_code;
				wattr = {in_item.format_flags, in_item.bg_index, in_item.fg_index};
			end
			default: ;
		endcase
	end

	// grow the dirty rectangle by one rectangle
	typedef struct packed {
		logic [5:0] top;
		logic [6:0] left;
		logic [6:0] rows;
		logic [7:0] cols;
	} rect_t;

	function automatic rect_t grow(input rect_t d, input rect_t n);
		rect_t o;
		logic [7:0] b0, b1;
		logic [8:0] r0, r1;
		if (n.rows == '0 || n.cols == '0) return d;
		if (d.rows == '0 || d.cols == '0) return n;
		b0 = {2'b0, d.top} + {1'b0, d.rows};
		r0 = {2'b0, d.left} + {1'b0, d.cols};
		b1 = {2'b0, n.top} + {1'b0, n.rows};
		r1 = {2'b0, n.left} + {1'b0, n.cols};
		o.top = (n.top < d.top) ? n.top : d.top;
		o.left = (n.left < d.left) ? n.left : d.left;
		if (b1 > b0) b0 = b1;
		if (r1 > r0) r0 = r1;
		o.rows = 7'(b0 - {2'b0, o.top});
		o.cols = 8'(r0 - {2'b0, o.left});
		return o;
	endfunction

	rect_t dcur, dnew;
	assign dcur = '{d_top_q, d_left_q, d_rows_q, d_cols_q};

	// dirty update for put, fill and copy, taken from the held item
	always_comb begin
		dnew = dcur;
		case (func_t'(it_q.func))
			FN_PUT: dnew = grow(dcur, '{it_q.row, it_q.col, 7'd1, 8'd1});
			FN_FILL: if (fill_ok)
				dnew = grow(dcur, '{it_q.row, it_q.col, fh_n[6:0], fw_n});
			FN_COPY: dnew = grow(dcur, '{it_q.dst_row, it_q.dst_col, ch_n[6:0], cw_n});
			default: ;
		endcase
	end

	rect_t dcur2;
	always_comb begin
		dcur2 = grow(dcur, '{it_q.row, it_q.col, 7'd1, 8'd1});
		dcur2 = grow(dcur2, '{it_q.dst_row, it_q.dst_col, 7'd1, 8'd1});
	end

	// status after the held item, and the result built from it
	rect_t dres;
	logic [7:0] bells_d;
	logic touched_d, shown_d;
	out_item_t res_d;
	always_comb begin
		dres = dcur;
		bells_d = bells_q;
		touched_d = touched_q;
		shown_d = shown_q;
		case (func_t'(it_q.func))
			FN_PUT: dres = dnew;
			FN_BELL: if (bells_q != 8'hff) bells_d = bells_q + 8'd1;
			FN_CURSOR: if (it_q.row != it_q.dst_row || it_q.col != it_q.dst_col) begin
				touched_d = 1'b1;
				dres = dcur2;
			end
			FN_VIS: begin
				shown_d = it_q.flag_value;
				touched_d = 1'b1;
			end
			default: ;
		endcase
		res_d = {rc_q, rf_q, rfg_q, rbg_q, dres, bells_d, touched_d, shown_d};
	end

	logic out_load;
	assign out_load = (state_q == ST_DONE) && (!out_valid || out_ready);

	assign in_ready = (state_q == ST_IDLE);

	// sequencer, state registers and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			d_top_q <= '0; d_left_q <= '0; d_rows_q <= '0; d_cols_q <= '0;
			bells_q <= '0; touched_q <= 1'b0; shown_q <= 1'b1;
			out_valid <= 1'b0;
			i_q <= '0; j_q <= '0;
		end else begin
			if (out_load) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AddrW'(Cells - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: if (in_valid) begin
					it_q <= in_item;
					i_q <= '0; j_q <= '0;
					rc_q <= '0; rf_q <= '0; rfg_q <= '0; rbg_q <= '0;
					case (func_t'(in_item.func))
						FN_FILL: state_q <= ST_FILL;
						FN_COPY: state_q <= ST_CRD;
						FN_READ: state_q <= ST_RD;
						default: state_q <= ST_DONE;
					endcase
				end
				ST_FILL: begin
					if (!fill_ok) state_q <= ST_DONE;
					else if (8'(j_q) + 8'd1 == fw_n) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (8'(i_q) + 8'd1 == fh_n) begin
							{d_top_q, d_left_q, d_rows_q, d_cols_q} <= dnew;
							state_q <= ST_DONE;
						end
					end else j_q <= j_q + 1'b1;
				end
				ST_CRD: begin
					if (!copy_ok || ch_n == '0 || cw_n == '0) state_q <= ST_DONE;
					else state_q <= ST_CWR;
				end
				ST_CWR: begin
					if (8'(j_q) + 8'd1 == cw_n) begin
						j_q <= '0;
						i_q <= i_q + 1'b1;
						if (8'(i_q) + 8'd1 == ch_n) begin
							{d_top_q, d_left_q, d_rows_q, d_cols_q} <= dnew;
							state_q <= ST_DONE;
						end else state_q <= ST_CRD;
					end else begin
						j_q <= j_q + 1'b1;
						state_q <= ST_CRD;
					end
				end
				ST_RD: begin
					rc_q <= rchar;
					rf_q <= rattr[8:6];
					if (rattr[9]) begin
						rbg_q <= rattr[6] ? pal_bright(rattr[2:0]) : pal_normal(rattr[2:0]);
						rfg_q <= pal_normal(rattr[5:3]);
					end else begin
						rfg_q <= rattr[6] ? pal_bright(rattr[2:0]) : pal_normal(rattr[2:0]);
						rbg_q <= pal_normal(rattr[5:3]);
					end
					state_q <= ST_DONE;
				end
				ST_DONE: if (out_load) begin
					out_item <= res_d;
					state_q <= ST_IDLE;
					// take reports the old status, then clears the dirty rectangle, bells and touched flag
					if (func_t'(it_q.func) == FN_TAKE) begin
						d_top_q <= '0; d_left_q <= '0; d_rows_q <= '0; d_cols_q <= '0;
						bells_q <= '0; touched_q <= 1'b0;
					end else begin
						{d_top_q, d_left_q, d_rows_q, d_cols_q} <= dres;
						bells_q <= bells_d;
						touched_q <= touched_d;
						shown_q <= shown_d;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Testbench for text_grid_blit_engine_top: random and directed cell, fill, copy,
// read, bell, cursor, visibility and take items, with a behavioral grid model and scoreboard.
// Depends on tgb_pkg and the block's RTL.
module tb_top;
	import tgb_pkg::*;

	class grid_scoreboard;
		logic [20:0] chars [Cells];
		logic [9:0]  attrs [Cells];
		int unsigned d_top, d_left, d_rows, d_cols;
		int unsigned bell_cnt;
		bit touched, shown;
		out_item_t pending [$];
		int errors;
		int checked;

		function new();
			foreach (chars[i]) begin
				chars[i] = '0;
				attrs[i] = '0;
			end
			d_top = 0; d_left = 0; d_rows = 0; d_cols = 0;
			bell_cnt = 0; touched = 0; shown = 1;
			errors = 0; checked = 0;
		endfunction

		function void grow(int unsigned t, int unsigned l, int unsigned h, int unsigned w);
			int unsigned b0, r0;
			if (h == 0 || w == 0) return;
			if (d_rows == 0 || d_cols == 0) begin
				d_top = t; d_left = l; d_rows = h; d_cols = w;
				return;
			end
			b0 = d_top + d_rows;
			r0 = d_left + d_cols;
			if (t < d_top) d_top = t;
			if (l < d_left) d_left = l;
			if (t + h > b0) b0 = t + h;
			if (l + w > r0) r0 = l + w;
			d_rows = b0 - d_top;
			d_cols = r0 - d_left;
		endfunction

		function void fill_status(ref out_item_t o);
			o.dirty_top = 6'(d_top);
			o.dirty_left = 7'(d_left);
			o.dirty_rows = 7'(d_rows);
			o.dirty_cols = 8'(d_cols);
			o.bells = 8'(bell_cnt);
			o.cursor_touched = touched;
			o.cursor_shown = shown;
		endfunction

		// Apply one accepted item to the grid model and queue its expected result.
		function void note_item(in_item_t it);
			out_item_t o;
			int unsigned er, ec, h, w, rr, cc, s, d;
			logic [9:0] a;
			logic [3:0] fmt;
			logic [23:0] t;
			o = '0;
			a = {it.format_flags, it.bg_index, it.fg_index};
			case (func_t'(it.func))
				FN_PUT: begin
					chars[it.row * MaxCols + it.col] = it.char_code;
					attrs[it.row * MaxCols + it.col] = a;
					grow(it.row, it.col, 1, 1);
				end
				FN_FILL: begin
					er = it.end_row > MaxRows ? MaxRows : it.end_row;
					ec = it.end_col > MaxCols ? MaxCols : it.end_col;
					if (er > it.row && ec > it.col) begin
						for (int r = it.row; r < er; r++)
							for (int c = it.col; c < ec; c++) begin
								chars[r * MaxCols + c] = it.char_code;
								attrs[r * MaxCols + c] = a;
							end
						grow(it.row, it.col, er - it.row, ec - it.col);
					end
				end
				FN_COPY: begin
					if (it.end_row > it.row && it.end_col > it.col) begin
						h = it.end_row - it.row;
						w = it.end_col - it.col;
						if (h > MaxRows - it.row) h = MaxRows - it.row;
						if (h > MaxRows - it.dst_row) h = MaxRows - it.dst_row;
						if (w > MaxCols - it.col) w = MaxCols - it.col;
						if (w > MaxCols - it.dst_col) w = MaxCols - it.dst_col;
						for (int i = 0; i < h; i++) begin
							rr = (it.dst_row <= it.row) ? i : h - 1 - i;
							for (int j = 0; j < w; j++) begin
								cc = (it.dst_col <= it.col) ? j : w - 1 - j;
								s = (it.row + rr) * MaxCols + it.col + cc;
								d = (it.dst_row + rr) * MaxCols + it.dst_col + cc;
								chars[d] = chars[s];
								attrs[d] = attrs[s];
							end
						end
						grow(it.dst_row, it.dst_col, h, w);
					end
				end
				FN_READ: begin
					a = attrs[it.row * MaxCols + it.col];
					fmt = a[9:6];
					o.read_char = chars[it.row * MaxCols + it.col];
					o.attr_flags = fmt[2:0];
					o.fg_rgb = fmt[0] ? pal_bright(a[2:0]) : pal_normal(a[2:0]);
					o.bg_rgb = pal_normal(a[5:3]);
					if (fmt[3]) begin
						t = o.fg_rgb; o.fg_rgb = o.bg_rgb; o.bg_rgb = t;
					end
				end
				FN_BELL: if (bell_cnt < 255) bell_cnt++;
				FN_CURSOR: begin
					if (it.row != it.dst_row || it.col != it.dst_col) begin
						touched = 1;
						grow(it.row, it.col, 1, 1);
						grow(it.dst_row, it.dst_col, 1, 1);
					end
				end
				FN_VIS: begin
					shown = it.flag_value;
					touched = 1;
				end
				default: begin
					// report the state before clearing
					fill_status(o);
					pending.push_back(o);
					d_top = 0; d_left = 0; d_rows = 0; d_cols = 0;
					bell_cnt = 0; touched = 0;
					return;
				end
			endcase
			fill_status(o);
			pending.push_back(o);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			checked++;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result %h", got);
				return;
			end
			want = pending.pop_front();
			if (got !== want) begin
				errors++;
				if (errors <= 10) begin
					$display("mismatch at result %0d", checked);
					$display("  expected char %h flags %h fg %h bg %h dirty %0d,%0d %0dx%0d",
						want.read_char, want.attr_flags, want.fg_rgb, want.bg_rgb,
						want.dirty_top, want.dirty_left, want.dirty_rows, want.dirty_cols);
					$display("  actual   char %h flags %h fg %h bg %h dirty %0d,%0d %0dx%0d",
						got.read_char, got.attr_flags, got.fg_rgb, got.bg_rgb,
						got.dirty_top, got.dirty_left, got.dirty_rows, got.dirty_cols);
					$display("  expected bells %0d touched %0b shown %0b; actual %0d %0b %0b",
						want.bells, want.cursor_touched, want.cursor_shown,
						got.bells, got.cursor_touched, got.cursor_shown);
				end
			end
		endfunction
	endclass

	localparam int StallLimit = 200000;
	localparam int InW = $bits(in_item_t);

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 0;
	out_item_t out_item;

	grid_scoreboard sb = new();
	bit hold_receiver = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int ops_seen [8];

	text_grid_blit_engine_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
	);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 45) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// Offer one item and hold it until accepted.
	task automatic send_item(in_item_t it);
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_item(it);
		ops_seen[it.func]++;
		items_sent++;
	endtask

	task automatic send_gap(int n);
		if (n == 0) return;
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		while (sb.pending.size() != 0) @(posedge clk);
	endtask

	function automatic in_item_t mk(func_t f, int r, int c, int er, int ec,
			int dr, int dc, int ch, int fl);
		in_item_t it;
		it = '0;
		it.func = f;
		it.row = 6'(r); it.col = 7'(c); it.end_row = 7'(er); it.end_col = 8'(ec);
		it.dst_row = 6'(dr); it.dst_col = 7'(dc);
		it.char_code = 21'(ch);
		it.fg_index = 3'($urandom); it.bg_index = 3'($urandom);
		it.format_flags = 4'(fl);
		it.flag_value = 1'($urandom);
		return it;
	endfunction

	// Mostly small rectangles, a few large ones, with all fields randomized.
	function automatic in_item_t rand_item();
		in_item_t it;
		int p;
		it = InW'({$urandom, $urandom, $urandom});
		p = $urandom_range(0, 99);
		if (p < 18) it.func = FN_PUT;
		else if (p < 30) it.func = FN_FILL;
		else if (p < 42) it.func = FN_COPY;
		else if (p < 72) it.func = FN_READ;
		else if (p < 80) it.func = FN_BELL;
		else if (p < 88) it.func = FN_CURSOR;
		else if (p < 93) it.func = FN_VIS;
		else it.func = FN_TAKE;
		if (it.func == FN_FILL || it.func == FN_COPY) begin
			if ($urandom_range(0, 49) == 0) begin
				it.end_row = 7'($urandom_range(0, 64));
				it.end_col = 8'($urandom_range(0, 255));
			end else if ($urandom_range(0, 9) == 0) begin
				it.end_row = 7'(it.row + $urandom_range(0, 3) - 1);
				it.end_col = 8'(it.col + $urandom_range(0, 3) - 1);
			end else begin
				it.end_row = 7'(it.row + $urandom_range(1, 4));
				it.end_col = 8'(it.col + $urandom_range(1, 12));
			end
			if (it.func == FN_COPY && $urandom_range(0, 1)) begin
				it.dst_row = 6'(it.row + $urandom_range(0, 4) - 2);
				it.dst_col = 7'(it.col + $urandom_range(0, 8) - 4);
			end
		end
		if (it.func == FN_CURSOR && $urandom_range(0, 4) == 0) begin
			it.dst_row = it.row;
			it.dst_col = it.col;
		end
		// keep reads near recently written cells half the time
		if (it.func == FN_READ && $urandom_range(0, 1) && sb.d_rows != 0) begin
			it.row = 6'(sb.d_top + $urandom_range(0, sb.d_rows - 1));
			it.col = 7'(sb.d_left + $urandom_range(0, sb.d_cols - 1));
		end
		return it;
	endfunction

	// Receiver: random stalls, and a long hold-off when asked.
	always @(posedge clk) begin
		if (hold_receiver) out_ready <= 0;
		else out_ready <= ($urandom_range(0, 99) < 70);
	end

	// Check every accepted result.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) sb.check_result(out_item);
	end

	// Watchdog on cycles with no acceptance on either channel.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > StallLimit) begin
			$display("timeout with %0d results outstanding", sb.pending.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		in_item_t it;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes, every operation, special cases.
		send_item(mk(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(FN_PUT, 0, 0, 0, 0, 0, 0, 21'h10ffff, 4'hf));
		send_item(mk(FN_PUT, 63, 127, 0, 0, 0, 0, 21'h1fffff, 4'h9));
		send_item(mk(FN_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(FN_READ, 63, 127, 0, 0, 0, 0, 0, 0));
		send_item(mk(FN_TAKE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(FN_FILL, 60, 120, 127, 255, 0, 0, 21'h41, 4'h1));
		send_item(mk(FN_FILL, 5, 5, 5, 9, 0, 0, 21'h42, 4'h2));
		send_item(mk(FN_FILL, 9, 9, 3, 3, 0, 0, 21'h42, 4'h4));
		send_item(mk(FN_FILL, 0, 0, 3, 10, 0, 0, 21'h61, 4'h8));
		send_item(mk(FN_COPY, 0, 0, 3, 10, 1, 2, 0, 0));
		send_item(mk(FN_COPY, 1, 2, 4, 12, 0, 0, 0, 0));
		send_item(mk(FN_COPY, 0, 0, 100, 200, 62, 125, 0, 0));
		send_item(mk(FN_COPY, 4, 4, 4, 8, 0, 0, 0, 0));
		send_item(mk(FN_READ, 1, 3, 0, 0, 0, 0, 0, 0));
		send_item(mk(FN_CURSOR, 7, 7, 0, 0, 7, 7, 0, 0));
		send_item(mk(FN_CURSOR, 0, 0, 0, 0, 63, 127, 0, 0));
		it = mk(FN_VIS, 0, 0, 0, 0, 0, 0, 0, 0); it.flag_value = 0;
		send_item(it);
		it.flag_value = 1;
		send_item(it);
		repeat (260) send_item(mk(FN_BELL, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(FN_TAKE, 0, 0, 0, 0, 0, 0, 0, 0));
		send_item(mk(FN_TAKE, 0, 0, 0, 0, 0, 0, 0, 0));
		drain();

		// Long receiver hold-off while items keep coming.
		fork
			begin
				hold_receiver = 1;
				repeat (400) @(posedge clk);
				hold_receiver = 0;
			end
			repeat (8) send_item(rand_item());
		join
		drain();

		// Random items with gaps; an occasional full drain.
		for (int n = 0; n < 700; n++) begin
			send_item(rand_item());
			send_gap(gap_len());
			if ($urandom_range(0, 199) == 0) drain();
		end
		drain();
		repeat (200) @(posedge clk);

		$display("Sent %0d items: put %0d fill %0d copy %0d read %0d bell %0d", items_sent,
			ops_seen[0], ops_seen[1], ops_seen[2], ops_seen[3], ops_seen[4]);
		$display("cursor %0d visibility %0d take %0d; %0d results checked, %0d errors",
			ops_seen[5], ops_seen[6], ops_seen[7], sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end
endmodule
